// File: rtl/core/saf_pkg.sv
// ----------------------------------------------------------------------------
// saf_pkg: shared types and constants for the stop-and-go feed controller
// Holds the register map, move modes, the fixed-width configuration and
// result words, and small helpers used by the core modules.
// ----------------------------------------------------------------------------
package saf_pkg;

	// Default widths of position and tick counts
	localparam int POSITION_BITS_DEF = 21;
	localparam int TICK_BITS_DEF     = 16;

	// Configuration register indexes
	localparam logic [2:0] REG_MOVE_MODE       = 3'd0;
	localparam logic [2:0] REG_TARGET_COUNTS   = 3'd1;
	localparam logic [2:0] REG_DRIVE_DUTY      = 3'd2;
	localparam logic [2:0] REG_GO_TICKS        = 3'd3;
	localparam logic [2:0] REG_STOP_TICKS      = 3'd4;
	localparam logic [2:0] REG_SENSE_INTERVAL  = 3'd5;
	localparam logic [2:0] REG_SPEED_THRESHOLD = 3'd6;
	localparam logic [2:0] REG_TIMEOUT_TICKS   = 3'd7;

	localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;

	// Request kinds carried on the input word
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Move modes; the unused code behaves as plain drive
	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_TIMED  = 2'd1,
		MODE_SENSED = 2'd2
	} mode_t;

	// Fixed-width configuration registers (target travels separately)
	typedef struct packed {
		logic [1:0]  move_mode;
		logic [9:0]  drive_duty;
		logic [7:0]  go_ticks;
		logic [7:0]  stop_ticks;
		logic [7:0]  sense_interval;
		logic [15:0] speed_threshold;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// One result word, first field in the highest bits
	typedef struct packed {
		logic [15:0] elapsed_ticks;
		logic        timed_out;
		logic        move_done;
		logic [9:0]  motor_duty;
		logic        drive_reverse;
		logic        drive_on;
	} res_t;

	// Saturating 8-bit increment
	function automatic logic [7:0] sat_inc8(input logic [7:0] c);
		sat_inc8 = (&c) ? c : c + 8'd1;
	endfunction

endpackage

// File: rtl/core/saf_cfg_regs.sv
// ----------------------------------------------------------------------------
// saf_cfg_regs: configuration register file
// Decodes the write port into the move registers. Unknown indexes are
// dropped; there is no read-back.
// ----------------------------------------------------------------------------
module saf_cfg_regs #(
	parameter int POSITION_BITS = saf_pkg::POSITION_BITS_DEF,
	parameter int CFG_W         = (POSITION_BITS > 16) ? POSITION_BITS : 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [CFG_W-1:0]                cfg_wdata,
	output saf_pkg::cfg_t                   cfg,
	output logic signed [POSITION_BITS-1:0] target_counts
);
	import saf_pkg::*;

	cfg_t                            cfg_q;
	logic signed [POSITION_BITS-1:0] target_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                 <= '0;
			cfg_q.timeout_ticks   <= TIMEOUT_RESET;
			target_q              <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOVE_MODE:       cfg_q.move_mode       <= cfg_wdata[1:0];
				REG_TARGET_COUNTS:   target_q              <= cfg_wdata[POSITION_BITS-1:0];
				REG_DRIVE_DUTY:      cfg_q.drive_duty      <= cfg_wdata[9:0];
				REG_GO_TICKS:        cfg_q.go_ticks        <= cfg_wdata[7:0];
				REG_STOP_TICKS:      cfg_q.stop_ticks      <= cfg_wdata[7:0];
				REG_SENSE_INTERVAL:  cfg_q.sense_interval  <= cfg_wdata[7:0];
				REG_SPEED_THRESHOLD: cfg_q.speed_threshold <= cfg_wdata[15:0];
				REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg           = cfg_q;
	assign target_counts = target_q;

endmodule

// File: rtl/core/saf_move_step.sv
// ----------------------------------------------------------------------------
// saf_move_step: move state and per-word step logic
// Holds the move state and, for the word presented with step_en, computes
// the next state and the result word in one pass of compare logic.
// ----------------------------------------------------------------------------
module saf_move_step #(
	parameter int POSITION_BITS = saf_pkg::POSITION_BITS_DEF,
	parameter int TICK_BITS     = saf_pkg::TICK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  logic                            req_type,
	input  logic signed [POSITION_BITS-1:0] encoder_count,
	input  saf_pkg::cfg_t                   cfg,
	input  logic signed [POSITION_BITS-1:0] target_counts,
	output saf_pkg::res_t                   result
);
	import saf_pkg::*;

	localparam int GW  = (POSITION_BITS + 1 > 17) ? POSITION_BITS + 1 : 17;
	localparam int TCW = (TICK_BITS > 16) ? TICK_BITS : 16;

	// Move state
	logic                            active_q, paused_q, timeout_q;
	logic [7:0]                      go_q, pause_q;
	logic signed [POSITION_BITS-1:0] prev_q;
	logic [TICK_BITS-1:0]            tick_q;

	logic                            active_n, paused_n, timeout_n;
	logic [7:0]                      go_n, pause_n;
	logic signed [POSITION_BITS-1:0] prev_n;
	logic [TICK_BITS-1:0]            tick_n;

	// Starting point of this step: cleared on a start word
	logic                            start, run;
	logic                            cur_paused;
	logic [7:0]                      cur_go, cur_pause;
	logic signed [POSITION_BITS-1:0] cur_prev, pos;
	logic [TICK_BITS-1:0]            cur_tick;
	logic [POSITION_BITS-1:0]        pos_mag, tgt_mag, prev_mag;
	logic signed [GW-1:0]            gain, thresh;
	logic [TCW-1:0]                  tick_ext;
	logic                            reached, expired;
	logic                            drive;

	assign start      = step_en && (req_type == REQ_START);
	assign run        = step_en && (start || active_q);
	assign cur_paused = start ? 1'b0 : paused_q;
	assign cur_go     = start ? 8'd0 : go_q;
	assign cur_pause  = start ? 8'd0 : pause_q;
	assign cur_prev   = start ? '0 : prev_q;
	assign cur_tick   = start ? '0 : ((&tick_q) ? tick_q : tick_q + TICK_BITS'(1));
	assign pos        = start ? '0 : encoder_count;

	// Absolute counts; the most negative value maps to its magnitude unsigned
	assign pos_mag  = pos[POSITION_BITS-1] ? (~pos + 1'b1) : pos;
	assign tgt_mag  = target_counts[POSITION_BITS-1] ? (~target_counts + 1'b1) : target_counts;
	assign prev_mag = cur_prev[POSITION_BITS-1] ? (~cur_prev + 1'b1) : cur_prev;

	assign gain     = $signed(GW'(pos_mag)) - $signed(GW'(prev_mag));
	assign thresh   = $signed(GW'(cfg.speed_threshold));
	assign reached  = pos_mag >= tgt_mag;
	assign expired  = TCW'(cur_tick) >= TCW'(cfg.timeout_ticks);

	// Next state of the move
	always_comb begin
		active_n  = active_q;
		paused_n  = paused_q;
		timeout_n = timeout_q;
		go_n      = go_q;
		pause_n   = pause_q;
		prev_n    = prev_q;
		tick_n    = tick_q;
		if (run) begin
			active_n  = 1'b1;
			paused_n  = cur_paused;
			timeout_n = start ? 1'b0 : timeout_q;
			go_n      = cur_go;
			pause_n   = cur_pause;
			prev_n    = cur_prev;
			tick_n    = cur_tick;
			if (reached) begin
				active_n = 1'b0;
				paused_n = 1'b0;
			end else if (expired) begin
				active_n  = 1'b0;
				paused_n  = 1'b0;
				timeout_n = 1'b1;
			end else if (cfg.move_mode == MODE_TIMED || cfg.move_mode == MODE_SENSED) begin
				if (cur_paused) begin
					// Count out the pause, resume when it is over
					if (cur_pause >= cfg.stop_ticks) begin
						paused_n = 1'b0;
						pause_n  = sat_inc8(8'd0);
					end else begin
						pause_n  = sat_inc8(cur_pause);
					end
				end else if (cfg.move_mode == MODE_TIMED) begin
					// Go phase of fixed length
					if (cur_go >= cfg.go_ticks) begin
						paused_n = 1'b1;
						go_n     = sat_inc8(8'd0);
					end else begin
						go_n     = sat_inc8(cur_go);
					end
				end else begin
					// Sample progress once per sensing interval
					if (cur_go >= cfg.sense_interval) begin
						paused_n = gain < thresh;
						prev_n   = pos;
						go_n     = sat_inc8(8'd0);
					end else begin
						go_n     = sat_inc8(cur_go);
					end
				end
			end
		end
	end

	// Hold the move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			paused_q  <= 1'b0;
			timeout_q <= 1'b0;
			go_q      <= '0;
			pause_q   <= '0;
			prev_q    <= '0;
			tick_q    <= '0;
		end else if (step_en) begin
			active_q  <= active_n;
			paused_q  <= paused_n;
			timeout_q <= timeout_n;
			go_q      <= go_n;
			pause_q   <= pause_n;
			prev_q    <= prev_n;
			tick_q    <= tick_n;
		end
	end

	// Result word from the state after the step
	assign drive    = active_n && !paused_n;
	assign tick_ext = TCW'(tick_n);

	always_comb begin
		result.drive_on      = drive;
		result.drive_reverse = drive && target_counts[POSITION_BITS-1];
		result.motor_duty    = drive ? cfg.drive_duty : 10'd0;
		result.move_done     = !active_n;
		result.timed_out     = !active_n && timeout_n;
		result.elapsed_ticks = tick_ext[15:0];
	end

	// A pause only exists inside a move
	a_pause_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q |-> active_q)
		else $error("paused while no move is active");

	// The timeout flag is only left standing after the move ended
	a_timeout_ends_move: assert property (@(posedge clk) disable iff (!arst_n)
		timeout_q |-> !active_q)
		else $error("timeout flag set on an active move");

	// A tick outside a move leaves the tick count alone
	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && req_type == REQ_TICK && !active_q) |=> tick_q == $past(tick_q))
		else $error("idle tick changed the tick count");

endmodule

// File: rtl/core/stop_and_go_feed_controller_core.sv
// ----------------------------------------------------------------------------
// stop_and_go_feed_controller_core: feed motor move controller
// Input stage, move step logic and output register, taking one word per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream s_axis: tuser is the request kind (0 start a move, 1 one tick),
//  tdata holds the signed encoder count since move start. Every input word
//  gives exactly one result word on m_axis: drive enable, direction, duty,
//  move done, timeout flag and the saturating tick count.
//  Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the user
//  must write it only while no word is in flight, which the block itself does
//  not enforce; register changes apply to the next word. A result word passes
//  through the input register, then the result register, before it shows on
//  m_axis. Throughput: one word per cycle while the receiver does not stall,
//  set by the compare logic between the two registers.
//  Reset clears the move state (move_done reads 1), all configuration registers
//  to zero except the timeout, which comes up at all ones.
//  When the receiver stalls, the result register holds; the input register
//  still takes one more word, and s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module stop_and_go_feed_controller_core #(
	parameter int POSITION_BITS = saf_pkg::POSITION_BITS_DEF,
	parameter int TICK_BITS     = saf_pkg::TICK_BITS_DEF,
	parameter int IN_W          = ((POSITION_BITS + 7) / 8) * 8,
	parameter int CFG_W         = (POSITION_BITS > 16) ? POSITION_BITS : 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // encoder_count
	input  logic             s_axis_tuser,   // req_type
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// drive_on, drive_reverse, motor_duty, move_done, timed_out, elapsed_ticks
	output logic [31:0]      m_axis_tdata,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);
	import saf_pkg::*;

	cfg_t                            cfg;
	logic signed [POSITION_BITS-1:0] target_counts;
	res_t                            step_res;
	res_t                            res_q;

	logic                            in_valid_s1;
	logic                            req_type_s1;
	logic signed [POSITION_BITS-1:0] count_s1;
	logic                            out_valid_q;
	logic                            advance;

	saf_cfg_regs #(
		.POSITION_BITS (POSITION_BITS),
		.CFG_W         (CFG_W)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cfg           (cfg),
		.target_counts (target_counts)
	);

	// Step the held word into the result register when it is free
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_type_s1 <= s_axis_tuser;
			count_s1    <= s_axis_tdata[POSITION_BITS-1:0];
		end
	end

	saf_move_step #(
		.POSITION_BITS (POSITION_BITS),
		.TICK_BITS     (TICK_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.req_type      (req_type_s1),
		.encoder_count (count_s1),
		.cfg           (cfg),
		.target_counts (target_counts),
		.result        (step_res)
	);

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q};

	// Input side only stalls with a word held behind a stalled result
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (in_valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// A finished move never drives the motor
	a_done_not_driving: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_q.drive_on && res_q.move_done))
		else $error("motor driven on a finished move");

	// Reverse and duty only show while driving
	a_idle_outputs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res_q.drive_on) |->
			(!res_q.drive_reverse && res_q.motor_duty == 10'd0))
		else $error("direction or duty set while stopped");

endmodule
